FILE: design/bdrm_pkg.sv
// Package for the binary descriptor ratio matcher.
// Holds the shared widths, constants, codes and the inter-module types.
// No dependencies.
`default_nettype none

package bdrm_pkg;

   localparam int MAX_FEATURES = 2048;
   localparam int LANES        = 4;
   localparam int WORD_W       = 64;
   localparam int CNT_W        = 7;
   localparam int DIST_W       = 9;
   localparam int INDEX_W      = 11;
   localparam int COUNT_W      = 16;
   localparam int CSR_DATA_W   = 9;

   localparam logic [DIST_W-1:0]     DIST_NONE     = 9'd256;
   localparam logic [CSR_DATA_W-1:0] THRESHOLD_RST = 9'd50;
   localparam logic [CSR_DATA_W-1:0] RATIO_RST     = 9'd205;
   localparam logic [COUNT_W-1:0]    COUNT_MAX     = 16'hFFFF;

   localparam logic [WORD_W-1:0] POP_M1 = 64'h5555_5555_5555_5555;
   localparam logic [WORD_W-1:0] POP_M2 = 64'h3333_3333_3333_3333;
   localparam logic [WORD_W-1:0] POP_M4 = 64'h0F0F_0F0F_0F0F_0F0F;

   typedef enum logic {
      REQ_QUERY     = 1'b0,
      REQ_CANDIDATE = 1'b1
   } req_kind_type;

   typedef enum logic {
      CSR_THRESHOLD = 1'b0,
      CSR_RATIO     = 1'b1
   } csr_index_type;

   typedef logic [LANES-1:0][CNT_W-1:0] lane_counts_type;

   typedef struct packed {
      req_kind_type       kind;
      logic [INDEX_W-1:0] feature_index;
      logic               last;
      logic               restart;
   } stage_ctrl_type;

   typedef struct packed {
      logic               emit;
      logic               restart;
      logic [INDEX_W-1:0] query_index;
      logic [INDEX_W-1:0] best_index;
      logic               has_candidate;
      logic [DIST_W-1:0]  best_distance;
      logic [DIST_W-1:0]  second_distance;
   } token_type;

endpackage

`default_nettype wire

FILE: design/bdrm_lane.sv
// One distance lane: registered population count of a 64-bit word pair XOR.
// Depends on bdrm_pkg.
`default_nettype none

module bdrm_lane (
   input  wire logic                           clock,
   input  wire logic                           load,
   input  wire logic [bdrm_pkg::WORD_W-1:0]    query_word,
   input  wire logic [bdrm_pkg::WORD_W-1:0]    cand_word,
   output logic      [bdrm_pkg::CNT_W-1:0]     count_ff
);

   logic [bdrm_pkg::WORD_W-1:0] diff;
   logic [bdrm_pkg::WORD_W-1:0] pairs;
   logic [bdrm_pkg::WORD_W-1:0] nibbles;
   logic [bdrm_pkg::WORD_W-1:0] bytes_v;
   logic [bdrm_pkg::CNT_W-1:0]  count_in;

   always_comb begin
      diff    = query_word ^ cand_word;
      pairs   = diff - ((diff >> 1) & bdrm_pkg::POP_M1);
      nibbles = (pairs & bdrm_pkg::POP_M2) + ((pairs >> 2) & bdrm_pkg::POP_M2);
      bytes_v = (nibbles + (nibbles >> 4)) & bdrm_pkg::POP_M4;
      count_in = '0;
      for (int b = 0; b < bdrm_pkg::WORD_W / 8; b++) begin
         count_in = count_in + bdrm_pkg::CNT_W'(bytes_v[b*8 +: 8]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/bdrm_merge.sv
// Merging stage: sums the lane counts and keeps the best two distances of a group.
// Produces one token per closed group or count restart. Depends on bdrm_pkg.
`default_nettype none

module bdrm_merge (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            stage_valid,
   input  wire bdrm_pkg::stage_ctrl_type        stage_ctrl,
   input  wire bdrm_pkg::lane_counts_type       lane_counts,
   output logic                                 stage_take,
   output logic                                 tok_valid_ff,
   output bdrm_pkg::token_type                  tok_ff,
   input  wire logic                            tok_take
);

   logic [bdrm_pkg::INDEX_W-1:0] query_index_ff, query_index_in;
   logic [bdrm_pkg::DIST_W-1:0]  near_ff, near_in;
   logic [bdrm_pkg::DIST_W-1:0]  run_ff, run_in;
   logic [bdrm_pkg::INDEX_W-1:0] near_index_ff, near_index_in;
   logic                         near_valid_ff, near_valid_in;
   logic                         tok_valid_in;
   bdrm_pkg::token_type          tok_in;
   logic [bdrm_pkg::DIST_W-1:0]  cand_dist;
   logic [bdrm_pkg::DIST_W-1:0]  near_upd, run_upd;
   logic [bdrm_pkg::INDEX_W-1:0] near_index_upd;
   logic                         near_valid_upd;

   always_comb begin
      cand_dist = '0;
      for (int l = 0; l < bdrm_pkg::LANES; l++) begin
         cand_dist = cand_dist + bdrm_pkg::DIST_W'(lane_counts[l]);
      end

      near_upd       = near_ff;
      run_upd        = run_ff;
      near_index_upd = near_index_ff;
      near_valid_upd = near_valid_ff;
      if (int'(stage_ctrl.feature_index) < bdrm_pkg::MAX_FEATURES) begin
         if (cand_dist < near_ff) begin
            run_upd        = near_ff;
            near_upd       = cand_dist;
            near_index_upd = stage_ctrl.feature_index;
            near_valid_upd = 1'b1;
         end else if (cand_dist < run_ff) begin
            run_upd = cand_dist;
         end
      end

      stage_take = stage_valid && (!tok_valid_ff || tok_take);

      query_index_in = query_index_ff;
      near_in        = near_ff;
      run_in         = run_ff;
      near_index_in  = near_index_ff;
      near_valid_in  = near_valid_ff;
      tok_in         = tok_ff;
      tok_valid_in   = tok_valid_ff && !tok_take;

      if (stage_take) begin
         tok_in.emit        = stage_ctrl.last;
         tok_in.query_index = query_index_ff;
         if (stage_ctrl.kind == bdrm_pkg::REQ_QUERY) begin
            query_index_in        = stage_ctrl.feature_index;
            tok_in.restart        = stage_ctrl.restart;
            tok_in.query_index    = stage_ctrl.feature_index;
            tok_in.best_index     = '0;
            tok_in.has_candidate  = 1'b0;
            tok_in.best_distance  = bdrm_pkg::DIST_NONE;
            tok_in.second_distance = bdrm_pkg::DIST_NONE;
            tok_valid_in          = stage_ctrl.last || stage_ctrl.restart;
            near_in               = bdrm_pkg::DIST_NONE;
            run_in                = bdrm_pkg::DIST_NONE;
            near_index_in         = '0;
            near_valid_in         = 1'b0;
         end else begin
            tok_in.restart         = 1'b0;
            tok_in.best_index      = near_index_upd;
            tok_in.has_candidate   = near_valid_upd;
            tok_in.best_distance   = near_upd;
            tok_in.second_distance = run_upd;
            tok_valid_in           = stage_ctrl.last;
            if (stage_ctrl.last) begin
               near_in       = bdrm_pkg::DIST_NONE;
               run_in        = bdrm_pkg::DIST_NONE;
               near_index_in = '0;
               near_valid_in = 1'b0;
            end else begin
               near_in       = near_upd;
               run_in        = run_upd;
               near_index_in = near_index_upd;
               near_valid_in = near_valid_upd;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_index_ff <= '0;
         near_ff        <= bdrm_pkg::DIST_NONE;
         run_ff         <= bdrm_pkg::DIST_NONE;
         near_index_ff  <= '0;
         near_valid_ff  <= 1'b0;
         tok_valid_ff   <= 1'b0;
      end else begin
         query_index_ff <= query_index_in;
         near_ff        <= near_in;
         run_ff         <= run_in;
         near_index_ff  <= near_index_in;
         near_valid_ff  <= near_valid_in;
         tok_valid_ff   <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

endmodule

`default_nettype wire

FILE: design/binary_descriptor_ratio_matcher.sv
// Top level of the binary descriptor ratio matcher: input stage, four distance
// lanes, merging stage, ratio test and result register. Depends on bdrm_pkg,
// bdrm_lane and bdrm_merge.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  type, descriptor words, index, last, restart
//   rsp_      out        rsp_valid/rsp_ready  indices, distances, matched, match count
//   csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// A transaction is accepted every cycle while the pipeline flows. After the last
// transaction of a group is accepted, its result moves through the registers in
// order: the lane popcounts load on acceptance, then the merge token, then the ratio
// multiply and count update load the result register.
// Reset is synchronous and loads the default threshold and ratio.
// A stalled rsp_ready backs up through the stages to req_ready.
`default_nettype none

module binary_descriptor_ratio_matcher (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_type,
   input  wire logic [bdrm_pkg::WORD_W-1:0]           req_desc_word0,
   input  wire logic [bdrm_pkg::WORD_W-1:0]           req_desc_word1,
   input  wire logic [bdrm_pkg::WORD_W-1:0]           req_desc_word2,
   input  wire logic [bdrm_pkg::WORD_W-1:0]           req_desc_word3,
   input  wire logic [bdrm_pkg::INDEX_W-1:0]          req_feature_index,
   input  wire logic                                  req_last,
   input  wire logic                                  req_restart,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic      [bdrm_pkg::INDEX_W-1:0]          rsp_query_index,
   output logic      [bdrm_pkg::INDEX_W-1:0]          rsp_best_index,
   output logic                                       rsp_has_candidate,
   output logic      [bdrm_pkg::DIST_W-1:0]           rsp_best_distance,
   output logic      [bdrm_pkg::DIST_W-1:0]           rsp_second_distance,
   output logic                                       rsp_matched,
   output logic      [bdrm_pkg::COUNT_W-1:0]          rsp_match_count,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic                                  csr_index,
   input  wire logic [bdrm_pkg::CSR_DATA_W-1:0]       csr_data
);

   logic [bdrm_pkg::LANES-1:0][bdrm_pkg::WORD_W-1:0] query_ff, query_in;
   logic [bdrm_pkg::LANES-1:0][bdrm_pkg::WORD_W-1:0] cand_words;
   logic                              req_fire;
   logic                              stage_valid_ff, stage_valid_in;
   bdrm_pkg::stage_ctrl_type          stage_ctrl_ff, stage_ctrl_in;
   bdrm_pkg::lane_counts_type         lane_counts;
   logic                              stage_take;
   logic                              tok_valid;
   bdrm_pkg::token_type               tok;
   logic                              tok_take;
   logic                              out_free;
   logic [bdrm_pkg::CSR_DATA_W-1:0]   threshold_ff, threshold_in;
   logic [bdrm_pkg::CSR_DATA_W-1:0]   ratio_ff, ratio_in;
   logic [bdrm_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [bdrm_pkg::COUNT_W-1:0]      count_base;
   logic [17:0]                       ratio_prod;
   logic [17:0]                       best_scaled;
   logic                              ok;
   logic                              rsp_valid_ff, rsp_valid_in;
   bdrm_pkg::token_type               rsp_tok_ff, rsp_tok_in;
   logic                              rsp_matched_ff, rsp_matched_in;
   logic [bdrm_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   assign cand_words = {req_desc_word3, req_desc_word2, req_desc_word1, req_desc_word0};
   assign req_ready  = !stage_valid_ff || stage_take;
   assign req_fire   = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   always_comb begin
      query_in       = query_ff;
      stage_ctrl_in  = stage_ctrl_ff;
      stage_valid_in = stage_valid_ff && !stage_take;
      if (req_fire) begin
         stage_valid_in              = 1'b1;
         stage_ctrl_in.kind          = bdrm_pkg::req_kind_type'(req_type);
         stage_ctrl_in.feature_index = req_feature_index;
         stage_ctrl_in.last          = req_last;
         stage_ctrl_in.restart       = req_restart;
         if (bdrm_pkg::req_kind_type'(req_type) == bdrm_pkg::REQ_QUERY) begin
            query_in = cand_words;
         end
      end
   end

   for (genvar l = 0; l < bdrm_pkg::LANES; l++) begin : g_lane
      bdrm_lane u_lane (
         .clock      (clock),
         .load       (req_fire),
         .query_word (query_ff[l]),
         .cand_word  (cand_words[l]),
         .count_ff   (lane_counts[l])
      );
   end

   bdrm_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .stage_valid  (stage_valid_ff),
      .stage_ctrl   (stage_ctrl_ff),
      .lane_counts  (lane_counts),
      .stage_take   (stage_take),
      .tok_valid_ff (tok_valid),
      .tok_ff       (tok),
      .tok_take     (tok_take)
   );

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      tok_take    = tok_valid && (!tok.emit || out_free);
      ratio_prod  = 18'(ratio_ff) * 18'(tok.second_distance);
      best_scaled = {1'b0, tok.best_distance, 8'd0};
      ok = tok.has_candidate && (tok.best_distance < threshold_ff) &&
           (best_scaled < ratio_prod);
      count_base = tok.restart ? '0 : count_ff;

      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_tok_in     = rsp_tok_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_count_in   = rsp_count_ff;
      if (tok_take) begin
         count_in = count_base;
         if (tok.emit) begin
            if (ok && count_base != bdrm_pkg::COUNT_MAX) begin
               count_in = count_base + 16'd1;
            end
            rsp_valid_in   = 1'b1;
            rsp_tok_in     = tok;
            rsp_matched_in = ok;
            rsp_count_in   = count_in;
         end
      end

      threshold_in = threshold_ff;
      ratio_in     = ratio_ff;
      if (csr_valid && csr_ready) begin
         case (bdrm_pkg::csr_index_type'(csr_index))
            bdrm_pkg::CSR_THRESHOLD: threshold_in = csr_data;
            bdrm_pkg::CSR_RATIO:     ratio_in     = csr_data;
            default:                 threshold_in = threshold_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff       <= '0;
         stage_valid_ff <= 1'b0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         threshold_ff   <= bdrm_pkg::THRESHOLD_RST;
         ratio_ff       <= bdrm_pkg::RATIO_RST;
      end else begin
         query_ff       <= query_in;
         stage_valid_ff <= stage_valid_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         threshold_ff   <= threshold_in;
         ratio_ff       <= ratio_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ctrl_ff  <= stage_ctrl_in;
      rsp_tok_ff     <= rsp_tok_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_query_index     = rsp_tok_ff.query_index;
   assign rsp_best_index      = rsp_tok_ff.best_index;
   assign rsp_has_candidate   = rsp_tok_ff.has_candidate;
   assign rsp_best_distance   = rsp_tok_ff.best_distance;
   assign rsp_second_distance = rsp_tok_ff.second_distance;
   assign rsp_matched         = rsp_matched_ff;
   assign rsp_match_count     = rsp_count_ff;

`ifndef ASSERT_OFF
   a_no_candidate_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_candidate |-> !rsp_matched)
      else $error("match reported without a candidate");

   a_empty_group_defaults: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_candidate |->
         rsp_best_distance == bdrm_pkg::DIST_NONE &&
         rsp_second_distance == bdrm_pkg::DIST_NONE && rsp_best_index == '0)
      else $error("empty group result carries stale distances");

   a_best_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_candidate |->
         rsp_best_distance <= rsp_second_distance &&
         rsp_best_distance < bdrm_pkg::DIST_NONE)
      else $error("best distance not below second distance");

   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_matched |-> rsp_match_count != '0)
      else $error("accepted match left the count at zero");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/bdrm_match_checker.sv
// Checker for the binary descriptor ratio matcher: watches the request, result and
// register channels, predicts every group result and compares it field by field.
// Depends on bdrm_pkg.
module bdrm_match_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic                              req_type,
   input  wire logic [bdrm_pkg::WORD_W-1:0]       req_desc_word0,
   input  wire logic [bdrm_pkg::WORD_W-1:0]       req_desc_word1,
   input  wire logic [bdrm_pkg::WORD_W-1:0]       req_desc_word2,
   input  wire logic [bdrm_pkg::WORD_W-1:0]       req_desc_word3,
   input  wire logic [bdrm_pkg::INDEX_W-1:0]      req_feature_index,
   input  wire logic                              req_last,
   input  wire logic                              req_restart,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [bdrm_pkg::INDEX_W-1:0]      rsp_query_index,
   input  wire logic [bdrm_pkg::INDEX_W-1:0]      rsp_best_index,
   input  wire logic                              rsp_has_candidate,
   input  wire logic [bdrm_pkg::DIST_W-1:0]       rsp_best_distance,
   input  wire logic [bdrm_pkg::DIST_W-1:0]       rsp_second_distance,
   input  wire logic                              rsp_matched,
   input  wire logic [bdrm_pkg::COUNT_W-1:0]      rsp_match_count,
   input  wire logic                              csr_valid,
   input  wire logic                              csr_ready,
   input  wire logic                              csr_index,
   input  wire logic [bdrm_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                                     mismatch_count,
   output int                                     pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LINES = 40;

   typedef struct packed {
      logic [bdrm_pkg::INDEX_W-1:0] query_index;
      logic [bdrm_pkg::INDEX_W-1:0] best_index;
      logic                         has_candidate;
      logic [bdrm_pkg::DIST_W-1:0]  best_distance;
      logic [bdrm_pkg::DIST_W-1:0]  second_distance;
      logic                         matched;
      logic [bdrm_pkg::COUNT_W-1:0] match_count;
   } group_result_type;

   group_result_type                              expected_groups[$];
   logic [bdrm_pkg::LANES*bdrm_pkg::WORD_W-1:0]   query_bits;
   logic [bdrm_pkg::INDEX_W-1:0]                  query_feature;
   logic [bdrm_pkg::DIST_W-1:0]                   nearest_dist;
   logic [bdrm_pkg::DIST_W-1:0]                   runner_up_dist;
   logic [bdrm_pkg::INDEX_W-1:0]                  nearest_feature;
   logic                                          nearest_seen;
   logic [bdrm_pkg::COUNT_W-1:0]                  accepted_total;
   logic [bdrm_pkg::CSR_DATA_W-1:0]               threshold;
   logic [bdrm_pkg::CSR_DATA_W-1:0]               ratio;

   task automatic report(input string msg);
      if (mismatch_count < REPORT_LINES) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want) begin
         report($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   function automatic void clear_group();
      nearest_dist    = bdrm_pkg::DIST_NONE;
      runner_up_dist  = bdrm_pkg::DIST_NONE;
      nearest_feature = '0;
      nearest_seen    = 1'b0;
   endfunction

   function automatic group_result_type close_group();
      group_result_type r;
      logic             passes;
      passes = nearest_seen && nearest_dist < threshold &&
               int'(nearest_dist) * 256 < int'(ratio) * int'(runner_up_dist);
      if (passes && accepted_total != bdrm_pkg::COUNT_MAX) begin
         accepted_total++;
      end
      r.query_index     = query_feature;
      r.best_index      = nearest_feature;
      r.has_candidate   = nearest_seen;
      r.best_distance   = nearest_dist;
      r.second_distance = runner_up_dist;
      r.matched         = passes;
      r.match_count     = accepted_total;
      clear_group();
      return r;
   endfunction

   task automatic predict_request();
      logic [bdrm_pkg::DIST_W-1:0] distance;
      group_result_type            closed;
      if (bdrm_pkg::req_kind_type'(req_type) == bdrm_pkg::REQ_QUERY) begin
         if (req_restart) begin
            accepted_total = '0;
         end
         query_bits    = {req_desc_word3, req_desc_word2, req_desc_word1, req_desc_word0};
         query_feature = req_feature_index;
         clear_group();
      end else if (int'(req_feature_index) < bdrm_pkg::MAX_FEATURES) begin
         distance = bdrm_pkg::DIST_W'($countones(query_bits ^
                       {req_desc_word3, req_desc_word2, req_desc_word1, req_desc_word0}));
         if (distance < nearest_dist) begin
            runner_up_dist  = nearest_dist;
            nearest_dist    = distance;
            nearest_feature = req_feature_index;
            nearest_seen    = 1'b1;
         end else if (distance < runner_up_dist) begin
            runner_up_dist = distance;
         end
      end
      if (req_last) begin
         closed          = close_group();
         expected_groups = {expected_groups, closed};
      end
   endtask

   task automatic check_result();
      group_result_type want;
      if (expected_groups.size() == 0) begin
         report($sformatf("result for query %0d with nothing expected", rsp_query_index));
         return;
      end
      want = expected_groups.pop_front();
      compare_field("query_index", int'(rsp_query_index), int'(want.query_index));
      compare_field("best_index", int'(rsp_best_index), int'(want.best_index));
      compare_field("has_candidate", int'(rsp_has_candidate), int'(want.has_candidate));
      compare_field("best_distance", int'(rsp_best_distance), int'(want.best_distance));
      compare_field("second_distance", int'(rsp_second_distance),
                    int'(want.second_distance));
      compare_field("matched", int'(rsp_matched), int'(want.matched));
      compare_field("match_count", int'(rsp_match_count), int'(want.match_count));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         query_bits     = '0;
         query_feature  = '0;
         accepted_total = '0;
         threshold      = bdrm_pkg::THRESHOLD_RST;
         ratio          = bdrm_pkg::RATIO_RST;
         clear_group();
         expected_groups.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
         if (csr_valid && csr_ready) begin
            case (bdrm_pkg::csr_index_type'(csr_index))
               bdrm_pkg::CSR_THRESHOLD: threshold = csr_data;
               bdrm_pkg::CSR_RATIO:     ratio     = csr_data;
               default:                 threshold = threshold;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_request();
         end
      end
      pending_results = expected_groups.size();
   end

endmodule

FILE: tb/sv/binary_descriptor_ratio_matcher_test.sv
// Top of the binary descriptor ratio matcher testbench: clock, reset, register
// settings, directed and random descriptor groups, and the verdict.
// Depends on bdrm_pkg, the matcher RTL and bdrm_match_checker.
module binary_descriptor_ratio_matcher_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RANDOM_END     = 1_150;
   localparam int ITEM_TARGET    = 1_250;
   localparam int SETTLE_CYCLES  = 8;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_type = 1'b0;
   logic [bdrm_pkg::WORD_W-1:0]     req_desc_word0 = '0;
   logic [bdrm_pkg::WORD_W-1:0]     req_desc_word1 = '0;
   logic [bdrm_pkg::WORD_W-1:0]     req_desc_word2 = '0;
   logic [bdrm_pkg::WORD_W-1:0]     req_desc_word3 = '0;
   logic [bdrm_pkg::INDEX_W-1:0]    req_feature_index = '0;
   logic                            req_last = 1'b0;
   logic                            req_restart = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [bdrm_pkg::INDEX_W-1:0]    rsp_query_index;
   logic [bdrm_pkg::INDEX_W-1:0]    rsp_best_index;
   logic                            rsp_has_candidate;
   logic [bdrm_pkg::DIST_W-1:0]     rsp_best_distance;
   logic [bdrm_pkg::DIST_W-1:0]     rsp_second_distance;
   logic                            rsp_matched;
   logic [bdrm_pkg::COUNT_W-1:0]    rsp_match_count;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic                            csr_index = 1'b0;
   logic [bdrm_pkg::CSR_DATA_W-1:0] csr_data = '0;

   int                              mismatch_count;
   int                              pending_results;
   int                              cycle_count = 0;
   int                              items_sent = 0;
   bit                              req_gaps_on = 1'b1;
   bit                              rsp_stall_on = 1'b1;
   logic [255:0]                    active_query = '0;

   binary_descriptor_ratio_matcher u_dut (.*);

   bdrm_match_checker u_check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (rsp_stall_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic [255:0] random_bits();
      logic [255:0] v;
      for (int w = 0; w < 8; w++) begin
         v[w*32 +: 32] = $urandom;
      end
      return v;
   endfunction

   function automatic logic [255:0] flip_bits(input logic [255:0] base, input int count);
      logic [255:0] v;
      int           start;
      v     = base;
      start = $urandom_range(0, 255);
      for (int b = 0; b < count; b++) begin
         v[(start + b) % 256] = ~v[(start + b) % 256];
      end
      return v;
   endfunction

   function automatic logic [255:0] near_candidate(input logic [255:0] query);
      case ($urandom_range(0, 7))
         0:       return random_bits();
         1:       return flip_bits(query, $urandom_range(0, 256));
         default: return flip_bits(query, $urandom_range(0, 70));
      endcase
   endfunction

   function automatic logic [bdrm_pkg::CSR_DATA_W-1:0] pick_setting(input int top);
      case ($urandom_range(0, 5))
         0:       return bdrm_pkg::CSR_DATA_W'(0);
         1:       return bdrm_pkg::CSR_DATA_W'(1);
         2:       return bdrm_pkg::CSR_DATA_W'(top - 1);
         3:       return bdrm_pkg::CSR_DATA_W'(top);
         default: return bdrm_pkg::CSR_DATA_W'($urandom_range(0, top));
      endcase
   endfunction

   function automatic logic [bdrm_pkg::INDEX_W-1:0] random_index();
      return bdrm_pkg::INDEX_W'($urandom_range(0, bdrm_pkg::MAX_FEATURES - 1));
   endfunction

   task automatic send_req(input bdrm_pkg::req_kind_type kind, input logic [255:0] desc,
                           input logic [bdrm_pkg::INDEX_W-1:0] index, input logic last,
                           input logic restart);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      {req_desc_word3, req_desc_word2, req_desc_word1, req_desc_word0} <= desc;
      req_feature_index <= index;
      req_last          <= last;
      req_restart       <= restart;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [bdrm_pkg::CSR_DATA_W-1:0] threshold,
                             input logic [bdrm_pkg::CSR_DATA_W-1:0] ratio);
      for (int k = 0; k < 2; k++) begin
         csr_valid <= 1'b1;
         csr_index <= (k == 0) ? bdrm_pkg::CSR_THRESHOLD : bdrm_pkg::CSR_RATIO;
         csr_data  <= (k == 0) ? threshold : ratio;
         @(negedge clock);
         while (!csr_ready) @(negedge clock);
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_group();
      int shape;
      int cands;
      shape = $urandom_range(0, 9);
      cands = $urandom_range(0, 6);
      if (shape < 9) begin
         active_query = random_bits();
         send_req(bdrm_pkg::REQ_QUERY, active_query, random_index(),
                  shape != 8 && cands == 0, $urandom_range(0, 7) == 0);
      end else if (cands == 0) begin
         cands = 1;
      end
      for (int c = 0; c < cands; c++) begin
         send_req(bdrm_pkg::REQ_CANDIDATE, near_candidate(active_query), random_index(),
                  shape != 8 && c == cands - 1, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      logic [255:0] q;
      int           phase_end;
      int           steps[12]  = '{10, 30, 49, 100, 50, 20, 20, 255, 45, 40, 30, 60};
      bit           closes[12] = '{0, 1, 0, 1, 1, 0, 1, 1, 0, 1, 0, 1};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      q = {256{1'b1}};
      send_req(bdrm_pkg::REQ_CANDIDATE, random_bits(), 11'd5, 1'b0, 1'b1);
      send_req(bdrm_pkg::REQ_CANDIDATE, '0, 11'd2047, 1'b1, 1'b0);
      send_req(bdrm_pkg::REQ_QUERY, q, 11'd2047, 1'b1, 1'b0);
      send_req(bdrm_pkg::REQ_QUERY, q, 11'd0, 1'b0, 1'b1);
      send_req(bdrm_pkg::REQ_CANDIDATE, '0, 11'd1, 1'b0, 1'b0);
      send_req(bdrm_pkg::REQ_CANDIDATE, q, 11'd2047, 1'b0, 1'b0);
      send_req(bdrm_pkg::REQ_CANDIDATE, q, 11'd3, 1'b1, 1'b0);

      q = random_bits();
      send_req(bdrm_pkg::REQ_QUERY, q, random_index(), 1'b0, 1'b0);
      for (int s = 0; s < 12; s++) begin
         send_req(bdrm_pkg::REQ_CANDIDATE, flip_bits(q, steps[s]),
                  random_index(), closes[s], 1'b0);
      end

      hold_until_drained();
      set_config(9'd257, 9'd256);
      send_req(bdrm_pkg::REQ_CANDIDATE, flip_bits(q, 200), 11'd0, 1'b1, 1'b0);
      send_req(bdrm_pkg::REQ_QUERY, q, 11'd1, 1'b1, 1'b0);

      hold_until_drained();
      set_config(9'd0, 9'd0);
      send_req(bdrm_pkg::REQ_CANDIDATE, q, 11'd2, 1'b1, 1'b0);
      active_query = q;

      while (items_sent < RANDOM_END) begin
         hold_until_drained();
         set_config(pick_setting(257), pick_setting(256));
         req_gaps_on  = $urandom_range(0, 4) != 0;
         rsp_stall_on = $urandom_range(0, 4) != 0;
         phase_end    = items_sent + $urandom_range(60, 150);
         while (items_sent < phase_end) begin
            random_group();
         end
      end

      // The closing stretch runs without idling on either side.
      hold_until_drained();
      req_gaps_on  = 1'b0;
      rsp_stall_on = 1'b0;
      set_config(9'd257, 9'd256);
      while (items_sent < ITEM_TARGET) begin
         random_group();
      end
      q = random_bits();
      send_req(bdrm_pkg::REQ_QUERY, q, 11'd7, 1'b1, 1'b1);
      send_req(bdrm_pkg::REQ_CANDIDATE, flip_bits(q, 3), 11'd9, 1'b1, 1'b0);

      hold_until_drained();
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
